// ===== rtl/core/dawd_pkg.sv =====
// ----------------------------------------------------------------------------
// dawd_pkg: shared types and constants for the date adder
// Holds the micro-operation and jump-condition codes, the control word, the
// datapath status bundle and the calendar helper functions.
// ----------------------------------------------------------------------------
package dawd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ADD_W   = 16;
  localparam int WDAY_W  = 3;
  localparam int DSUM_W  = 17;
  localparam int ACC_W   = 14;
  localparam int C400_W  = 9;
  localparam int K_W     = 4;
  localparam int PC_W    = 4;
  localparam int YLEN_W  = 9;
  localparam int DBEF_W  = 9;

  localparam logic [YEAR_W-1:0]  YEAR_MAX_IN  = 14'd9799;
  localparam logic [MONTH_W-1:0] MONTH_FIRST  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST   = 4'd12;
  localparam logic [C400_W-1:0]  C400_LAST    = 9'd399;
  localparam logic [K_W-1:0]     K400_TOP     = 4'd4;
  localparam logic [K_W-1:0]     K7_TOP       = 4'd10;

  // p / 100 == (p * 5243) >> 19 holds exactly for every p below 43699.
  localparam int DIV100_W     = 13;
  localparam logic [DIV100_W-1:0] DIV100_MUL = 13'd5243;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = YEAR_W + DIV100_W;
  localparam int Q100_W       = PROD_W - DIV100_SHIFT;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_LAST = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RED400,
    OP_SETC,
    OP_WALK,
    OP_PREP,
    OP_MUL,
    OP_SUM_A,
    OP_SUM_B,
    OP_RED7,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_K_NZ,
    COND_WALK_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic k_nz;
    logic walk_more;
  } dp_status_t;

  // Leap test from the year taken modulo 400.
  function automatic logic is_leap(input logic [C400_W-1:0] c);
    logic century;
    century = (c == 9'd0) || (c == 9'd100) || (c == 9'd200) || (c == 9'd300);
    return (c[1:0] == 2'b00) && ((c == 9'd0) || !century);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the months before month m of the same year.
  function automatic logic [DBEF_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DBEF_W-1:0] base;
    unique case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && (m > 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

// ===== rtl/core/date_add_days_weekday.sv =====
// ----------------------------------------------------------------------------
// date_add_days_weekday: Gregorian date plus a day count, with weekday
// Microcoded sequencer: a step counter reads a control store that drives
// the datapath, jumping on the datapath status and the handshakes.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | start_year, start_month,
//           |           |                      | start_day, add_days
//   out     | output    | out_valid / out_ready| result_year, result_month,
//           |           |                      | result_day, result_weekday
//
// The year-and-month walk makes one pass per whole year skipped from
// January and one per month stepped.
// Reset clears the step counter and the output valid flag.
// A new item is taken while the previous result still waits; the sequencer
// holds on its last step only if that result has not yet been taken.
// ----------------------------------------------------------------------------
module date_add_days_weekday #(
  parameter int EPOCH_YEAR = 1900
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dawd_pkg::YEAR_W-1:0]   start_year,
  input  logic [dawd_pkg::MONTH_W-1:0]  start_month,
  input  logic [dawd_pkg::DAY_W-1:0]    start_day,
  input  logic [dawd_pkg::ADD_W-1:0]    add_days,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dawd_pkg::YEAR_W-1:0]   result_year,
  output logic [dawd_pkg::MONTH_W-1:0]  result_month,
  output logic [dawd_pkg::DAY_W-1:0]    result_day,
  output logic [dawd_pkg::WDAY_W-1:0]   result_weekday
);

  dawd_pkg::pc_t        pc, pc_next;
  dawd_pkg::uword_t     ctl;
  dawd_pkg::dp_status_t status;
  logic                 out_busy;
  logic                 take;
  logic                 emit_en;

  dawd_ucode u_ucode (
    .pc  (pc),
    .ctl (ctl)
  );

  dawd_datapath #(
    .EPOCH_YEAR (EPOCH_YEAR)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .emit_en        (emit_en),
    .start_year     (start_year),
    .start_month    (start_month),
    .start_day      (start_day),
    .add_days       (add_days),
    .status         (status),
    .result_year    (result_year),
    .result_month   (result_month),
    .result_day     (result_day),
    .result_weekday (result_weekday)
  );

  always_comb begin
    out_busy = out_valid && !out_ready;
    unique case (ctl.cond)
      dawd_pkg::COND_NONE:      take = 1'b0;
      dawd_pkg::COND_ALWAYS:    take = 1'b1;
      dawd_pkg::COND_NO_INPUT:  take = !in_valid;
      dawd_pkg::COND_K_NZ:      take = status.k_nz;
      dawd_pkg::COND_WALK_MORE: take = status.walk_more;
      dawd_pkg::COND_OUT_BUSY:  take = out_busy;
      default:                  take = 1'b0;
    endcase
    if (take) begin
      pc_next = ctl.target;
    end else if (pc >= dawd_pkg::PC_LAST) begin
      pc_next = '0;
    end else begin
      pc_next = pc + 1'b1;
    end
    in_ready = (ctl.op == dawd_pkg::OP_LOAD);
    emit_en  = (ctl.op == dawd_pkg::OP_EMIT) && !out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (emit_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/dawd_ucode.sv =====
// ----------------------------------------------------------------------------
// dawd_ucode: control store of the date adder
// Read-only program: one control word per step, giving the datapath
// operation, the jump condition and the jump target.
// ----------------------------------------------------------------------------
module dawd_ucode (
  input  dawd_pkg::pc_t    pc,
  output dawd_pkg::uword_t ctl
);

  localparam dawd_pkg::pc_t ST_LOAD   = 4'd0;
  localparam dawd_pkg::pc_t ST_RED400 = 4'd1;
  localparam dawd_pkg::pc_t ST_SETC   = 4'd2;
  localparam dawd_pkg::pc_t ST_WALK   = 4'd3;
  localparam dawd_pkg::pc_t ST_PREP   = 4'd4;
  localparam dawd_pkg::pc_t ST_MUL    = 4'd5;
  localparam dawd_pkg::pc_t ST_SUM_A  = 4'd6;
  localparam dawd_pkg::pc_t ST_SUM_B  = 4'd7;
  localparam dawd_pkg::pc_t ST_RED7   = 4'd8;
  localparam dawd_pkg::pc_t ST_EMIT   = 4'd9;

  always_comb begin
    unique case (pc)
      ST_LOAD:   ctl = '{dawd_pkg::OP_LOAD,   dawd_pkg::COND_NO_INPUT,  ST_LOAD};
      ST_RED400: ctl = '{dawd_pkg::OP_RED400, dawd_pkg::COND_K_NZ,      ST_RED400};
      ST_SETC:   ctl = '{dawd_pkg::OP_SETC,   dawd_pkg::COND_NONE,      ST_LOAD};
      ST_WALK:   ctl = '{dawd_pkg::OP_WALK,   dawd_pkg::COND_WALK_MORE, ST_WALK};
      ST_PREP:   ctl = '{dawd_pkg::OP_PREP,   dawd_pkg::COND_NONE,      ST_LOAD};
      ST_MUL:    ctl = '{dawd_pkg::OP_MUL,    dawd_pkg::COND_NONE,      ST_LOAD};
      ST_SUM_A:  ctl = '{dawd_pkg::OP_SUM_A,  dawd_pkg::COND_NONE,      ST_LOAD};
      ST_SUM_B:  ctl = '{dawd_pkg::OP_SUM_B,  dawd_pkg::COND_NONE,      ST_LOAD};
      ST_RED7:   ctl = '{dawd_pkg::OP_RED7,   dawd_pkg::COND_K_NZ,      ST_RED7};
      ST_EMIT:   ctl = '{dawd_pkg::OP_EMIT,   dawd_pkg::COND_OUT_BUSY,  ST_EMIT};
      default:   ctl = '{dawd_pkg::OP_NOP,    dawd_pkg::COND_ALWAYS,    ST_LOAD};
    endcase
  end

endmodule

// ===== rtl/core/dawd_datapath.sv =====
// ----------------------------------------------------------------------------
// dawd_datapath: registers and arithmetic of the date adder
// Clamps and loads the item, walks years and months, and reduces the day
// count modulo 7 with a shared restoring compare-and-subtract unit.
// ----------------------------------------------------------------------------
module dawd_datapath #(
  parameter int EPOCH_YEAR = 1900
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dawd_pkg::uword_t                 ctl,
  input  logic                             emit_en,
  input  logic [dawd_pkg::YEAR_W-1:0]      start_year,
  input  logic [dawd_pkg::MONTH_W-1:0]     start_month,
  input  logic [dawd_pkg::DAY_W-1:0]       start_day,
  input  logic [dawd_pkg::ADD_W-1:0]       add_days,
  output dawd_pkg::dp_status_t             status,
  output logic [dawd_pkg::YEAR_W-1:0]      result_year,
  output logic [dawd_pkg::MONTH_W-1:0]     result_month,
  output logic [dawd_pkg::DAY_W-1:0]       result_day,
  output logic [dawd_pkg::WDAY_W-1:0]      result_weekday
);

  localparam int LoPrev   = EPOCH_YEAR - 1;
  localparam int LbLo     = LoPrev / 4 - LoPrev / 100 + LoPrev / 400;
  localparam int WdOffset = 14 - (EPOCH_YEAR % 7) - (LbLo % 7);
  localparam logic [dawd_pkg::YEAR_W-1:0] EPOCH  = dawd_pkg::YEAR_W'(EPOCH_YEAR);
  localparam logic [dawd_pkg::ACC_W-1:0]  OFFSET = dawd_pkg::ACC_W'(WdOffset);

  logic [dawd_pkg::YEAR_W-1:0]  y;
  logic [dawd_pkg::MONTH_W-1:0] m;
  logic [dawd_pkg::DSUM_W-1:0]  d;
  logic [dawd_pkg::C400_W-1:0]  c400;
  logic [dawd_pkg::YEAR_W-1:0]  p;
  logic [dawd_pkg::PROD_W-1:0]  prod;
  logic [dawd_pkg::ACC_W-1:0]   acc;
  logic [dawd_pkg::K_W-1:0]     k;
  logic                         late;

  logic [dawd_pkg::YEAR_W-1:0]  y_lo, y_cl;
  logic [dawd_pkg::MONTH_W-1:0] m_cl;
  logic [dawd_pkg::DAY_W-1:0]   d_cl;
  logic [dawd_pkg::DSUM_W-1:0]  d_sum;
  logic                         leap;
  logic [dawd_pkg::DAY_W-1:0]   mlen;
  logic [dawd_pkg::YLEN_W-1:0]  ylen;
  logic                         year_skip, month_skip;
  logic [dawd_pkg::C400_W-1:0]  c400_inc;
  logic [dawd_pkg::C400_W-1:0]  red_base;
  logic [dawd_pkg::ACC_W:0]     red_sub;
  logic                         red_take;
  logic [dawd_pkg::Q100_W-1:0]  q100;
  logic [dawd_pkg::ACC_W-1:0]   sum_a, sum_b;

  always_comb begin
    y_lo  = (start_year < EPOCH) ? EPOCH : start_year;
    y_cl  = (y_lo > dawd_pkg::YEAR_MAX_IN) ? dawd_pkg::YEAR_MAX_IN : y_lo;
    if (start_month == '0) begin
      m_cl = dawd_pkg::MONTH_FIRST;
    end else if (start_month > dawd_pkg::MONTH_LAST) begin
      m_cl = dawd_pkg::MONTH_LAST;
    end else begin
      m_cl = start_month;
    end
    d_cl  = (start_day == '0) ? dawd_pkg::DAY_W'(1) : start_day;
    d_sum = dawd_pkg::DSUM_W'(d_cl) + dawd_pkg::DSUM_W'(add_days);

    leap       = dawd_pkg::is_leap(c400);
    mlen       = dawd_pkg::month_len(m, leap);
    ylen       = leap ? 9'd366 : 9'd365;
    year_skip  = (m == dawd_pkg::MONTH_FIRST) && (d > dawd_pkg::DSUM_W'(ylen));
    month_skip = d > dawd_pkg::DSUM_W'(mlen);
    c400_inc   = (c400 == dawd_pkg::C400_LAST) ? '0 : c400 + 1'b1;

    red_base = (ctl.op == dawd_pkg::OP_RED7) ? 9'd7 : 9'd400;
    red_sub  = (dawd_pkg::ACC_W + 1)'(red_base) << k;
    red_take = {1'b0, acc} >= red_sub;

    q100  = prod[dawd_pkg::PROD_W-1:dawd_pkg::DIV100_SHIFT];
    sum_a = late ? dawd_pkg::ACC_W'(d[dawd_pkg::DAY_W-1:0])
                 : y + dawd_pkg::ACC_W'(p[dawd_pkg::YEAR_W-1:2])
                   + dawd_pkg::ACC_W'(d[dawd_pkg::DAY_W-1:0]) + OFFSET;
    sum_b = late ? acc + dawd_pkg::ACC_W'(dawd_pkg::days_before(m, leap))
                 : acc - dawd_pkg::ACC_W'(q100) + dawd_pkg::ACC_W'(q100[dawd_pkg::Q100_W-1:2])
                   + dawd_pkg::ACC_W'(dawd_pkg::days_before(m, leap));

    status.k_nz      = (k != '0);
    status.walk_more = month_skip;
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      dawd_pkg::OP_LOAD: begin
        y   <= y_cl;
        m   <= m_cl;
        d   <= d_sum;
        acc <= y_cl;
        k   <= dawd_pkg::K400_TOP;
      end
      dawd_pkg::OP_RED400, dawd_pkg::OP_RED7: begin
        if (red_take) begin
          acc <= acc - red_sub[dawd_pkg::ACC_W-1:0];
        end
        k <= k - 1'b1;
      end
      dawd_pkg::OP_SETC: begin
        c400 <= acc[dawd_pkg::C400_W-1:0];
        k    <= dawd_pkg::K7_TOP;
      end
      dawd_pkg::OP_WALK: begin
        if (year_skip) begin
          d    <= d - dawd_pkg::DSUM_W'(ylen);
          y    <= y + 1'b1;
          c400 <= c400_inc;
        end else if (month_skip) begin
          d <= d - dawd_pkg::DSUM_W'(mlen);
          if (m == dawd_pkg::MONTH_LAST) begin
            m    <= dawd_pkg::MONTH_FIRST;
            y    <= y + 1'b1;
            c400 <= c400_inc;
          end else begin
            m <= m + 1'b1;
          end
        end
      end
      dawd_pkg::OP_PREP: begin
        p    <= y - 1'b1;
        late <= y < EPOCH;
      end
      dawd_pkg::OP_MUL: begin
        prod <= dawd_pkg::PROD_W'(p) * dawd_pkg::PROD_W'(dawd_pkg::DIV100_MUL);
      end
      dawd_pkg::OP_SUM_A: begin
        acc <= sum_a;
      end
      dawd_pkg::OP_SUM_B: begin
        acc <= sum_b;
      end
      dawd_pkg::OP_EMIT: begin
        if (emit_en) begin
          result_year    <= y;
          result_month   <= m;
          result_day     <= d[dawd_pkg::DAY_W-1:0];
          result_weekday <= acc[dawd_pkg::WDAY_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_weekday_reduced: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == dawd_pkg::OP_EMIT) |-> (acc < dawd_pkg::ACC_W'(7)))
    else $error("weekday residue not reduced below seven");

  a_c400_reduced: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == dawd_pkg::OP_SETC) |-> (acc < dawd_pkg::ACC_W'(400)))
    else $error("year residue not reduced below four hundred");

  a_walk_done: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == dawd_pkg::OP_PREP) |->
      (m >= dawd_pkg::MONTH_FIRST) && (m <= dawd_pkg::MONTH_LAST) &&
      (d >= dawd_pkg::DSUM_W'(1)) && (d <= dawd_pkg::DSUM_W'(mlen)))
    else $error("month walk left a date outside its month");
`endif

endmodule

// ===== test/date_add_days_weekday_checker.sv =====
// ----------------------------------------------------------------------------
// date_add_days_weekday_checker: result checker for the date adder
// Watches both channels of the block. Every accepted input item is turned
// into the expected date and weekday by a calendar walk of its own, and
// every accepted result item is compared field by field with the oldest
// expected date. It reports the number of failures and of dates still due.
// ----------------------------------------------------------------------------
module date_add_days_weekday_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [dawd_pkg::YEAR_W-1:0]   start_year,
  input  logic [dawd_pkg::MONTH_W-1:0]  start_month,
  input  logic [dawd_pkg::DAY_W-1:0]    start_day,
  input  logic [dawd_pkg::ADD_W-1:0]    add_days,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [dawd_pkg::YEAR_W-1:0]   result_year,
  input  logic [dawd_pkg::MONTH_W-1:0]  result_month,
  input  logic [dawd_pkg::DAY_W-1:0]    result_day,
  input  logic [dawd_pkg::WDAY_W-1:0]   result_weekday,
  output int                            failures,
  output int                            dates_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EPOCH = 1900;
  localparam int unsigned LAST_START_YEAR = 9799;

  typedef struct packed {
    logic [dawd_pkg::YEAR_W-1:0]  year;
    logic [dawd_pkg::MONTH_W-1:0] month;
    logic [dawd_pkg::DAY_W-1:0]   day;
    logic [dawd_pkg::WDAY_W-1:0]  weekday;
  } calendar_date_t;

  calendar_date_t expected_dates[$];

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_of_month(input int unsigned y, input int unsigned m);
    int unsigned n;
    case (m)
      2:           n = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: n = 30;
      default:     n = 31;
    endcase
    return n;
  endfunction

  function automatic int unsigned leaps_up_to(input int unsigned y);
    int unsigned p;
    p = (y > 0) ? y - 1 : 0;
    return p / 4 - p / 100 + p / 400;
  endfunction

  function automatic calendar_date_t shift_date(input logic [dawd_pkg::YEAR_W-1:0] sy,
                                                input logic [dawd_pkg::MONTH_W-1:0] sm,
                                                input logic [dawd_pkg::DAY_W-1:0] sd,
                                                input logic [dawd_pkg::ADD_W-1:0] span);
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned days_since;
    int unsigned k;
    calendar_date_t r;
    y = sy;
    m = sm;
    d = sd;
    if (y < EPOCH) y = EPOCH;
    if (y > LAST_START_YEAR) y = LAST_START_YEAR;
    if (m == 0) m = 1;
    if (m > 12) m = 12;
    if (d == 0) d = 1;
    d = d + span;
    while (d > days_of_month(y, m)) begin
      d = d - days_of_month(y, m);
      m = m + 1;
      if (m == 13) begin
        m = 1;
        y = y + 1;
      end
    end
    days_since = 365 * (y - EPOCH) + leaps_up_to(y) - leaps_up_to(EPOCH);
    for (k = 1; k < m; k++) days_since = days_since + days_of_month(y, k);
    days_since = days_since + d;
    r.year    = y[dawd_pkg::YEAR_W-1:0];
    r.month   = m[dawd_pkg::MONTH_W-1:0];
    r.day     = d[dawd_pkg::DAY_W-1:0];
    r.weekday = 3'(days_since % 7);
    return r;
  endfunction

  always @(posedge clk) begin
    calendar_date_t seen;
    calendar_date_t want;
    if (rst) begin
      expected_dates.delete();
      failures  <= 0;
      dates_due <= 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = '{result_year, result_month, result_day, result_weekday};
        if (expected_dates.size() == 0) begin
          if (failures < 10)
            $display("%0t: unexpected result %0d-%0d-%0d weekday %0d", $realtime,
                     seen.year, seen.month, seen.day, seen.weekday);
          failures <= failures + 1;
        end else begin
          want = expected_dates.pop_front();
          if (seen.year !== want.year || seen.month !== want.month ||
              seen.day !== want.day || seen.weekday !== want.weekday) begin
            if (failures < 10)
              $display("%0t: expected %0d-%0d-%0d weekday %0d, got %0d-%0d-%0d weekday %0d",
                       $realtime, want.year, want.month, want.day, want.weekday,
                       seen.year, seen.month, seen.day, seen.weekday);
            failures <= failures + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_dates.push_back(shift_date(start_year, start_month, start_day, add_days));
      dates_due <= expected_dates.size();
    end
  end

endmodule

// ===== test/date_add_days_weekday_test.sv =====
// ----------------------------------------------------------------------------
// date_add_days_weekday_test: testbench for the date adder
// Drives directed dates (range edges, clamped fields, leap and century
// years, year wrap, overlong days) and then 1250 random items, with
// random gaps on the input and random stalls on the output. The checker
// predicts and compares each result; this module gives the verdict.
// ----------------------------------------------------------------------------
module date_add_days_weekday_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1250;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [dawd_pkg::YEAR_W-1:0]   start_year;
  logic [dawd_pkg::MONTH_W-1:0]  start_month;
  logic [dawd_pkg::DAY_W-1:0]    start_day;
  logic [dawd_pkg::ADD_W-1:0]    add_days;
  logic                          out_valid;
  logic                          out_ready;
  logic [dawd_pkg::YEAR_W-1:0]   result_year;
  logic [dawd_pkg::MONTH_W-1:0]  result_month;
  logic [dawd_pkg::DAY_W-1:0]    result_day;
  logic [dawd_pkg::WDAY_W-1:0]   result_weekday;
  int                            failures;
  int                            dates_due;
  bit                            steady_input;

  date_add_days_weekday #(
    .EPOCH_YEAR(1900)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .start_year(start_year),
    .start_month(start_month),
    .start_day(start_day),
    .add_days(add_days),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_year(result_year),
    .result_month(result_month),
    .result_day(result_day),
    .result_weekday(result_weekday)
  );

  date_add_days_weekday_checker u_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .start_year(start_year),
    .start_month(start_month),
    .start_day(start_day),
    .add_days(add_days),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_year(result_year),
    .result_month(result_month),
    .result_day(result_day),
    .result_weekday(result_weekday),
    .failures(failures),
    .dates_due(dates_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("date_add_days_weekday_test: FAIL");
    $finish;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic offer_date(input int y, input int m, input int d, input int span);
    int gap;
    gap = steady_input ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    start_year  <= y[dawd_pkg::YEAR_W-1:0];
    start_month <= m[dawd_pkg::MONTH_W-1:0];
    start_day   <= d[dawd_pkg::DAY_W-1:0];
    add_days    <= span[dawd_pkg::ADD_W-1:0];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic int random_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 60);
    if (r < 80) return $urandom_range(0, 1500);
    return $urandom_range(0, 65535);
  endfunction

  task automatic offer_random_date();
    int r;
    int y;
    int m;
    int d;
    r = $urandom_range(0, 99);
    y = $urandom_range(1900, 9799);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, 28);
    if (r < 50) begin
      if ($urandom_range(0, 3) == 0) d = $urandom_range(1, 31);
      offer_date(y, m, d, random_span());
    end else if (r < 62) begin
      y = ($urandom_range(0, 1) == 0) ? $urandom_range(1900, 1910) : $urandom_range(9790, 9799);
      offer_date(y, m, d, random_span());
    end else if (r < 75) begin
      y = 4 * $urandom_range(475, 2449);
      if ($urandom_range(0, 1) == 0) offer_date(y, 2, $urandom_range(27, 29), $urandom_range(0, 3));
      else offer_date(y, 12, 31, $urandom_range(0, 400));
    end else begin
      offer_date($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                 $urandom_range(0, 65535));
    end
  endtask

  initial begin
    int stall;
    bit ready_now;
    out_ready = 1'b0;
    ready_now = 1'b1;
    stall = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (stall == 0) begin
        ready_now = ~ready_now;
        if (ready_now)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 20);
        else
          stall = idle_length() + 1;
      end
      stall = stall - 1;
      out_ready <= ready_now;
    end
  end

  initial begin
    int n;
    rst          = 1'b1;
    in_valid     = 1'b0;
    start_year   = '0;
    start_month  = '0;
    start_day    = '0;
    add_days     = '0;
    steady_input = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    offer_date(1900, 1, 1, 0);
    offer_date(0, 1, 1, 0);
    offer_date(1899, 6, 15, 10);
    offer_date(16383, 15, 31, 65535);
    offer_date(9799, 12, 31, 65535);
    offer_date(9800, 3, 3, 0);
    offer_date(1900, 1, 1, 65535);
    offer_date(2023, 0, 10, 5);
    offer_date(2023, 13, 10, 5);
    offer_date(2023, 15, 0, 0);
    offer_date(2023, 5, 0, 0);
    offer_date(2001, 2, 31, 0);
    offer_date(2023, 4, 31, 0);
    offer_date(2000, 2, 28, 1);
    offer_date(1900, 2, 28, 1);
    offer_date(2100, 2, 28, 1);
    offer_date(2004, 2, 29, 365);
    offer_date(1999, 12, 31, 1);
    offer_date(2024, 1, 31, 29);
    offer_date(8191, 7, 16, 32768);
    offer_date(5461, 10, 21, 21845);
    offer_date(1900, 12, 31, 0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) steady_input = ($urandom_range(0, 3) == 0);
      offer_random_date();
    end
    in_valid <= 1'b0;

    while (dates_due != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (failures == 0 && dates_due == 0) begin
      $display("date_add_days_weekday_test: PASS");
    end else begin
      $display("date_add_days_weekday_test: FAIL");
    end
    $finish;
  end

endmodule
